// File: sv/rbam_pkg.sv
// ============================================================================
// rbam_pkg
// Shared types, stage numbering and per-stage arithmetic for the rational
// Bezier arc midpoint pipeline.
// ============================================================================
package rbam_pkg;

  // Fixed-point formats.
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_BITS = 16;
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  // Digit counts of the unrolled square root and division stages.
  localparam int SQRT_STEPS = 32;
  localparam int WDIV_STEPS = WEIGHT_BITS;
  localparam int QDIV_STEPS = 62;

  // Stage numbering.
  localparam int ST_DIFF    = 0;
  localparam int ST_SUM     = 1;
  localparam int ST_SQ      = 2;
  localparam int ST_SP      = 3;
  localparam int ST_PROD    = 4;
  localparam int ST_DOT     = 5;
  localparam int ST_SQRT0   = 6;
  localparam int ST_DEN     = ST_SQRT0 + SQRT_STEPS;
  localparam int ST_WSET    = ST_DEN + 1;
  localparam int ST_DIV0    = ST_WSET + 1;
  localparam int ST_CW      = ST_DIV0 + QDIV_STEPS;
  localparam int ST_OUT     = ST_CW + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  // Magnitude limits for the prescale shift.
  localparam logic [32:0] LIM30 = 33'h040000000;
  localparam logic [32:0] LIM31 = 33'h080000000;

  // Everything one arc carries down the pipeline.
  typedef struct packed {
    logic [2:0][31:0] c;
    logic [2:0][32:0] a;
    logic [2:0][32:0] b;
    logic [2:0][33:0] s;
    logic [1:0]       k;
    logic             azero;
    logic [2:0][65:0] sq;
    logic [2:0][30:0] ap;
    logic [2:0][30:0] bp;
    logic [2:0][31:0] sp;
    logic [67:0]      sumsq;
    logic [2:0][59:0] asq;
    logic [2:0][61:0] ssq;
    logic [2:0][62:0] dot;
    logic             fault;
    logic [63:0]      xa;
    logic [63:0]      xs;
    logic [63:0]      ra;
    logic [63:0]      rs;
    logic [63:0]      d;
    logic [62:0]      den;
    logic [63:0]      wrem;
    logic [16:0]      w;
    logic             wact;
    logic [2:0][61:0] nq;
    logic [2:0]       neg;
    logic [2:0][32:0] qrem;
    logic [2:0][31:0] cw;
    logic [2:0][31:0] mid;
  } pipe_t;

  function automatic logic [32:0] mag33(input logic [32:0] x);
    return x[32] ? (33'd0 - x) : x;
  endfunction

  function automatic logic [33:0] mag34(input logic [33:0] x);
    return x[33] ? (34'd0 - x) : x;
  endfunction

  // Magnitude shifted right by k with the sign put back.
  function automatic logic [30:0] shrink(input logic [32:0] x, input logic [1:0] k);
    logic [32:0] m;
    logic [30:0] r;
    m = mag33(x) >> k;
    r = m[30:0];
    return x[32] ? (31'd0 - r) : r;
  endfunction

  // Work of stage g on the contents of stage g-1.
  function automatic pipe_t stage_calc(input int unsigned g, input pipe_t x,
                                       input logic [31:0] min_len);
    pipe_t              y;
    logic [32:0]        ma;
    logic [32:0]        mb;
    logic [33:0]        m34;
    logic [67:0]        pr;
    logic               lt30;
    logic               lt31;
    logic               az;
    logic signed [63:0] e1;
    logic signed [63:0] e2;
    logic signed [63:0] pw;
    logic [63:0]        mg;
    logic [63:0]        bitv;
    logic [64:0]        t65;
    logic [32:0]        r;
    logic               qb;
    logic [63:0]        wr;
    logic [16:0]        wq;
    logic [31:0]        m32;
    logic [63:0]        tm;
    logic signed [65:0] sum;
    logic signed [65:0] dsum;
    y    = x;
    lt30 = 1'b1;
    lt31 = 1'b1;
    az   = 1'b1;
    if (g == ST_SUM) begin
      // Sum vector, prescale shift and zero-radius check.
      for (int i = 0; i < 3; i++) begin
        ma = mag33(x.a[i]);
        mb = mag33(x.b[i]);
        y.s[i] = {x.a[i][32], x.a[i]} + {x.b[i][32], x.b[i]};
        if (ma >= LIM30 || mb >= LIM30) lt30 = 1'b0;
        if (ma >= LIM31 || mb >= LIM31) lt31 = 1'b0;
        if (x.a[i] != 33'd0) az = 1'b0;
      end
      y.k     = lt30 ? 2'd0 : (lt31 ? 2'd1 : 2'd2);
      y.azero = az;
    end else if (g == ST_SQ) begin
      // Exact squares of the sum vector, and the differences prescaled by k.
      for (int i = 0; i < 3; i++) begin
        m34 = mag34(x.s[i]);
        pr = {34'd0, m34} * {34'd0, m34};
        y.sq[i] = pr[65:0];
        y.ap[i] = shrink(x.a[i], x.k);
        y.bp[i] = shrink(x.b[i], x.k);
      end
    end else if (g == ST_SP) begin
      y.sumsq = {2'b0, x.sq[0]} + {2'b0, x.sq[1]} + {2'b0, x.sq[2]};
      for (int i = 0; i < 3; i++) begin
        y.sp[i] = {x.ap[i][30], x.ap[i]} + {x.bp[i][30], x.bp[i]};
      end
    end else if (g == ST_PROD) begin
      // Products for |a'|^2, |s'|^2 and a'.s', plus the length fault.
      for (int i = 0; i < 3; i++) begin
        e1 = 64'($signed(x.ap[i]));
        e2 = 64'($signed(x.sp[i]));
        pw = e1 * e1;
        y.asq[i] = pw[59:0];
        pw = e2 * e2;
        y.ssq[i] = pw[61:0];
        pw = e1 * e2;
        y.dot[i] = pw[62:0];
      end
      y.fault = x.azero || ((x.sumsq >> FRAC_BITS) <= {36'd0, min_len});
    end else if (g == ST_DOT) begin
      y.xa = {4'd0, x.asq[0]} + {4'd0, x.asq[1]} + {4'd0, x.asq[2]};
      y.xs = {2'd0, x.ssq[0]} + {2'd0, x.ssq[1]} + {2'd0, x.ssq[2]};
      y.ra = 64'd0;
      y.rs = 64'd0;
      dsum = 66'($signed(x.dot[0])) + 66'($signed(x.dot[1]))
           + 66'($signed(x.dot[2]));
      y.d = dsum[63:0];
    end else if (g >= ST_SQRT0 && g < ST_DEN) begin
      // One digit of each integer square root.
      bitv = 64'd1 << (62 - 2 * (g - ST_SQRT0));
      t65 = {1'b0, x.ra} + {1'b0, bitv};
      if ({1'b0, x.xa} >= t65) begin
        y.xa = x.xa - t65[63:0];
        y.ra = (x.ra >> 1) + bitv;
      end else begin
        y.ra = x.ra >> 1;
      end
      t65 = {1'b0, x.rs} + {1'b0, bitv};
      if ({1'b0, x.xs} >= t65) begin
        y.xs = x.xs - t65[63:0];
        y.rs = (x.rs >> 1) + bitv;
      end else begin
        y.rs = x.rs >> 1;
      end
    end else if (g == ST_DEN) begin
      // Weight denominator and the numerators of s' * ra / rs.
      e1 = {33'd0, x.ra[30:0]};
      e2 = {32'd0, x.rs[31:0]};
      pw = e1 * e2;
      y.den = pw[62:0];
      y.fault = x.fault || (x.ra == 64'd0) || (x.rs == 64'd0);
      for (int i = 0; i < 3; i++) begin
        e2 = 64'($signed(x.sp[i]));
        pw = e2 * e1;
        mg = pw[63] ? (64'd0 - pw) : pw;
        y.nq[i]   = mg[61:0];
        y.neg[i]  = x.sp[i][31];
        y.qrem[i] = 33'd0;
      end
    end else if (g == ST_WSET) begin
      // Clamp the cosine, or start the weight division.
      y.wrem = x.d;
      if ($signed(x.d) <= 64'sd0) begin
        y.w = 17'd0;
        y.wact = 1'b0;
      end else if (x.d >= {1'b0, x.den}) begin
        y.w = WEIGHT_ONE;
        y.wact = 1'b0;
      end else begin
        y.w = 17'd0;
        y.wact = 1'b1;
      end
    end else if (g >= ST_DIV0 && g < ST_CW) begin
      // One quotient bit per lane, and one weight bit in the first steps.
      for (int i = 0; i < 3; i++) begin
        r = {x.qrem[i][31:0], x.nq[i][61]};
        if (r >= {1'b0, x.rs[31:0]}) begin
          r = r - {1'b0, x.rs[31:0]};
          qb = 1'b1;
        end else begin
          qb = 1'b0;
        end
        y.qrem[i] = r;
        y.nq[i] = {x.nq[i][60:0], qb};
      end
      if (g < ST_DIV0 + WDIV_STEPS && x.wact) begin
        wr = x.wrem << 1;
        wq = {x.w[15:0], 1'b0};
        if (wr >= {1'b0, x.den}) begin
          wr = wr - {1'b0, x.den};
          wq[0] = 1'b1;
        end
        y.wrem = wr;
        y.w = wq;
      end
    end else if (g == ST_CW) begin
      // Center times weight, truncated toward zero.
      for (int i = 0; i < 3; i++) begin
        e1 = 64'($signed(x.c[i]));
        e2 = {47'd0, x.w};
        pw = e1 * e2;
        mg = pw[63] ? (64'd0 - pw) : pw;
        m32 = mg[47:16];
        y.cw[i] = pw[63] ? (32'd0 - m32) : m32;
      end
    end else if (g == ST_OUT) begin
      // Final sum with saturation; a fault forces zeros.
      for (int i = 0; i < 3; i++) begin
        tm = {2'd0, x.nq[i]} << x.k;
        sum = (x.neg[i] ? (66'd0 - {2'd0, tm}) : {2'd0, tm})
            + {{34{x.cw[i][31]}}, x.cw[i]};
        if (sum > 66'sd2147483647) begin
          y.mid[i] = 32'h7FFFFFFF;
        end else if (sum < -66'sd2147483648) begin
          y.mid[i] = 32'h80000000;
        end else begin
          y.mid[i] = sum[31:0];
        end
        if (x.fault) y.mid[i] = 32'd0;
      end
      if (x.fault) y.w = 17'd0;
    end
    return y;
  endfunction

endpackage

// File: sv/rbam_ifs.sv
// ============================================================================
// rbam arc channels
// Valid/ready channels for arc requests and midpoint results.
// ============================================================================
interface rbam_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;

  modport source (output valid, start_x, start_y, start_z, center_x, center_y,
                  center_z, end_x, end_y, end_z, input ready);
  modport sink (input valid, start_x, start_y, start_z, center_x, center_y,
                center_z, end_x, end_y, end_z, output ready);
endinterface

interface rbam_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mid_wx;
  logic signed [31:0] mid_wy;
  logic signed [31:0] mid_wz;
  logic        [16:0] weight;
  logic               fault;

  modport source (output valid, mid_wx, mid_wy, mid_wz, weight, fault,
                  input ready);
  modport sink (input valid, mid_wx, mid_wy, mid_wz, weight, fault,
                output ready);
endinterface

// File: sv/rational_bezier_arc_midpoint.sv
// ============================================================================
// rational_bezier_arc_midpoint
// Middle control point and weight of a circular arc as a rational quadratic
// Bezier curve, one arc per cycle while arc_out is not stalled.
// ============================================================================
// Usage:
//   Arc requests (start, center, end in signed Q16.16) arrive on arc_in and
//   each produces exactly one result on arc_out: the weighted middle point,
//   the weight in Q1.16 and a fault flag for half circles or zero radius.
//   A transaction moves when valid and ready are both high.
//   The block accepts one request every cycle while arc_out is not stalled;
//   the two square roots, the weight division and the three quotient
//   lanes are unrolled into one pipeline stage per digit, so the digit
//   count sets the pipeline depth, not the rate.
//   cfg_we/cfg_wdata write the fault threshold on the squared sum length;
//   write it only while the pipeline is empty. It resets to 1.
//   Synchronous reset empties the pipeline. When the receiver holds ready
//   low with a result waiting, the whole pipeline holds in place and
//   arc_in.ready drops; nothing is lost or repeated.
// ============================================================================
module rational_bezier_arc_midpoint
  import rbam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  rbam_in_if.sink     arc_in,
  rbam_out_if.source  arc_out
);

  logic [31:0]           min_len_squared;
  logic [NUM_STAGES-1:0] v;
  pipe_t                 p [NUM_STAGES];
  pipe_t                 nxt [1:NUM_STAGES-1];
  pipe_t                 first;
  logic                  adv;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_len_squared <= 32'd1;
    end else if (cfg_we) begin
      min_len_squared <= cfg_wdata;
    end
  end

  // The pipeline moves whenever the output slot is free or being taken.
  assign adv = arc_out.ready || !v[NUM_STAGES-1];
  assign arc_in.ready = adv;

  // Entry stage: differences from the center.
  always_comb begin
    first = '0;
    first.c[0] = arc_in.center_x;
    first.c[1] = arc_in.center_y;
    first.c[2] = arc_in.center_z;
    first.a[0] = {arc_in.start_x[31], arc_in.start_x}
               - {arc_in.center_x[31], arc_in.center_x};
    first.a[1] = {arc_in.start_y[31], arc_in.start_y}
               - {arc_in.center_y[31], arc_in.center_y};
    first.a[2] = {arc_in.start_z[31], arc_in.start_z}
               - {arc_in.center_z[31], arc_in.center_z};
    first.b[0] = {arc_in.end_x[31], arc_in.end_x}
               - {arc_in.center_x[31], arc_in.center_x};
    first.b[1] = {arc_in.end_y[31], arc_in.end_y}
               - {arc_in.center_y[31], arc_in.center_y};
    first.b[2] = {arc_in.end_z[31], arc_in.end_z}
               - {arc_in.center_z[31], arc_in.center_z};
  end

  // Per-stage arithmetic.
  for (genvar g = 1; g < NUM_STAGES; g++) begin : g_stage
    assign nxt[g] = stage_calc(g, p[g-1], min_len_squared);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NUM_STAGES-2:0], arc_in.valid};
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    if (adv) begin
      p[0] <= first;
      for (int g = 1; g < NUM_STAGES; g++) begin
        p[g] <= nxt[g];
      end
    end
  end

  // Result slot.
  assign arc_out.valid  = v[NUM_STAGES-1];
  assign arc_out.mid_wx = p[NUM_STAGES-1].mid[0];
  assign arc_out.mid_wy = p[NUM_STAGES-1].mid[1];
  assign arc_out.mid_wz = p[NUM_STAGES-1].mid[2];
  assign arc_out.weight = p[NUM_STAGES-1].w;
  assign arc_out.fault  = p[NUM_STAGES-1].fault;

`ifndef SYNTH
  // A faulted result carries all-zero values.
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    arc_out.valid && arc_out.fault |->
      arc_out.weight == 17'd0 && arc_out.mid_wx == 32'sd0 &&
      arc_out.mid_wy == 32'sd0 && arc_out.mid_wz == 32'sd0)
    else $error("faulted result with nonzero fields");

  // The weight never exceeds one.
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    arc_out.valid |-> arc_out.weight <= WEIGHT_ONE)
    else $error("weight above one");

  // An accepted transaction enters the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    arc_in.valid && arc_in.ready |=> v[0])
    else $error("accepted request lost at entry");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !arc_out.valid && v == '0)
    else $error("pipeline not empty after reset");
`endif

endmodule
